// ----- rtl/stlm_pkg.sv -----
// Package for the secid token LRU map: sizes, commands, sequencer states.
`timescale 1ns / 1ps
package stlm_pkg;

  localparam int ENTRIES = 256;
  localparam int MODULES = 8;
  localparam int AW      = $clog2(ENTRIES);
  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int IDS_W   = MODULES * 32;

  localparam logic [29:0] TOKEN_WRAP = 30'h2000_0000;
  localparam logic [29:0] AGE_WRAP   = 30'h1FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_MAP     = 2'd0,
    CMD_RESOLVE = 2'd1,
    CMD_GET     = 2'd2,
    CMD_SET     = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RES,
    S_RES_RD,
    S_RES_DATA,
    S_SET,
    S_MAP_CHK,
    S_MAP,
    S_MAP_END,
    S_DONE
  } state_t;

  typedef logic [MODULES-1:0][31:0] ids_t;

endpackage

// ----- rtl/stlm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module stlm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/secid_token_lru_map.sv -----
// Top level of the secid token LRU map: sequencer around token, id and age RAMs.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------
//  input   | in_valid  | in_stall  | cmd, token, module_index, new_secid,
//          |           |           | secid_0..secid_7
//  output  | out_valid | out_stall | token_out, selected_secid,
//          |           |           | out_secid_0..out_secid_7
//
// One item at a time. A scan reads one entry per cycle from the RAMs. A token
// lookup or an id lookup scans the filled entries, and a set does both, a token
// lookup and then an id lookup. Filled entries are tracked by a fill count, so
// reset does not clear the RAMs. The result register lets a new item in while
// the previous result waits on out_stall.
`timescale 1ns / 1ps
module secid_token_lru_map
  import stlm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] token,
  input  logic [2:0]  module_index,
  input  logic [31:0] new_secid,
  input  logic [31:0] secid_0,
  input  logic [31:0] secid_1,
  input  logic [31:0] secid_2,
  input  logic [31:0] secid_3,
  input  logic [31:0] secid_4,
  input  logic [31:0] secid_5,
  input  logic [31:0] secid_6,
  input  logic [31:0] secid_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] token_out,
  output logic [31:0] selected_secid,
  output logic [31:0] out_secid_0,
  output logic [31:0] out_secid_1,
  output logic [31:0] out_secid_2,
  output logic [31:0] out_secid_3,
  output logic [31:0] out_secid_4,
  output logic [31:0] out_secid_5,
  output logic [31:0] out_secid_6,
  output logic [31:0] out_secid_7
);

  state_t state, state_next;

  // item registers
  cmd_t        cmd_q;
  logic [31:0] tok_q;
  logic [2:0]  idx_q;
  logic [31:0] nid_q;
  ids_t        ids_q;
  logic [31:0] res_token;

  // table control
  logic [CW-1:0] fill;
  logic [CW-1:0] cnt;
  logic          rd_v;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] hit_addr;
  logic [29:0]   min_age;
  logic [AW-1:0] min_idx;
  logic [29:0]   age_cnt;
  logic [29:0]   tok_cnt;

  // RAM ports
  logic [31:0]    tok_rdata;
  logic [IDS_W-1:0] ids_rdata;
  logic [29:0]    age_rdata;
  logic [AW-1:0]  ids_raddr;
  logic [AW-1:0]  victim;
  logic           age_we;
  logic [AW-1:0]  age_waddr;

  logic        scan, issue, tok_hit, ids_hit, scan_end;
  logic [29:0] age_fresh, tok_fresh;
  logic [31:0] new_token;
  ids_t        in_ids;
  logic        out_free;

  assign in_ids = {secid_7, secid_6, secid_5, secid_4, secid_3, secid_2, secid_1, secid_0};

  // fresh counters with wrap before count
  assign age_fresh = ((age_cnt >= AGE_WRAP) ? 30'd0 : age_cnt) + 30'd1;
  assign tok_fresh = ((tok_cnt >= TOKEN_WRAP) ? 30'd0 : tok_cnt) + 30'd1;
  assign new_token = {2'b10, tok_fresh};

  // scan pipeline: issue one address per cycle, compare in the next cycle
  assign scan     = (state == S_RES) || (state == S_MAP);
  assign issue    = scan && (cnt < fill);
  assign tok_hit  = (state == S_RES) && rd_v && (tok_rdata == tok_q);
  assign ids_hit  = (state == S_MAP) && rd_v && (ids_rdata == IDS_W'(ids_q));
  assign scan_end = scan && !rd_v && !issue;
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd_t'(cmd) == CMD_MAP) begin
            state_next = S_MAP_CHK;
          end else if (token == 32'd0 || !token[31]) begin
            state_next = (cmd_t'(cmd) == CMD_SET) ? S_SET : S_DONE;
          end else begin
            state_next = S_RES;
          end
        end
      end
      S_RES: begin
        if (tok_hit) begin
          state_next = S_RES_RD;
        end else if (scan_end) begin
          state_next = (cmd_q == CMD_SET) ? S_SET : S_DONE;
        end
      end
      S_RES_RD:   state_next = S_RES_DATA;
      S_RES_DATA: state_next = (cmd_q == CMD_SET) ? S_SET : S_DONE;
      S_SET:      state_next = (ids_q[idx_q] == nid_q) ? S_DONE : S_MAP_CHK;
      S_MAP_CHK:  state_next = (ids_q == '0) ? S_DONE : S_MAP;
      S_MAP: begin
        if (ids_hit) begin
          state_next = S_DONE;
        end else if (scan_end) begin
          state_next = S_MAP_END;
        end
      end
      S_MAP_END:  state_next = S_DONE;
      S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    ids_raddr = (state == S_RES_RD) ? hit_addr : cnt[AW-1:0];
    victim    = (fill < CW'(ENTRIES)) ? fill[AW-1:0] : min_idx;
    age_we    = (state == S_RES_RD) || ids_hit || (state == S_MAP_END);
    if (state == S_RES_RD) begin
      age_waddr = hit_addr;
    end else if (ids_hit) begin
      age_waddr = rd_addr;
    end else begin
      age_waddr = victim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rd_v      <= 1'b0;
      age_cnt   <= '0;
      tok_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      // accept
      if (state == S_IDLE && in_valid) begin
        cmd_q     <= cmd_t'(cmd);
        tok_q     <= token;
        idx_q     <= module_index;
        nid_q     <= new_secid;
        res_token <= 32'd0;
        cnt       <= '0;
        if (cmd_t'(cmd) == CMD_MAP) begin
          ids_q <= in_ids;
        end else if (token == 32'd0) begin
          ids_q <= '0;
        end else begin
          ids_q <= {MODULES{token}};
        end
      end

      // scan stepping
      rd_v <= issue;
      if (issue) begin
        cnt     <= cnt + CW'(1);
        rd_addr <= cnt[AW-1:0];
      end

      // token lookup
      if (tok_hit) begin
        hit_addr <= rd_addr;
      end
      if (state == S_RES && scan_end) begin
        ids_q <= '0;
      end
      if (state == S_RES_RD) begin
        age_cnt <= age_fresh;
      end
      if (state == S_RES_DATA) begin
        ids_q <= ids_t'(ids_rdata);
      end

      // id replace
      if (state == S_SET) begin
        if (ids_q[idx_q] == nid_q) begin
          res_token <= tok_q;
        end else begin
          ids_q[idx_q] <= nid_q;
        end
      end
      if (state == S_MAP_CHK) begin
        cnt <= '0;
      end

      // id lookup with LRU tracking
      if (state == S_MAP && rd_v) begin
        if (rd_addr == '0 || age_rdata < min_age) begin
          min_age <= age_rdata;
          min_idx <= rd_addr;
        end
      end
      if (ids_hit) begin
        res_token <= tok_rdata;
        age_cnt   <= age_fresh;
      end

      // allocate
      if (state == S_MAP_END) begin
        tok_cnt   <= tok_fresh;
        age_cnt   <= age_fresh;
        res_token <= new_token;
        if (fill < CW'(ENTRIES)) begin
          fill <= fill + CW'(1);
        end
      end

      // result register
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      token_out      <= res_token;
      selected_secid <= (cmd_q == CMD_GET) ? ids_q[idx_q] : 32'd0;
      out_secid_0    <= (cmd_q == CMD_RESOLVE) ? ids_q[0] : 32'd0;
      out_secid_1    <= (cmd_q == CMD_RESOLVE) ? ids_q[1] : 32'd0;
      out_secid_2    <= (cmd_q == CMD_RESOLVE) ? ids_q[2] : 32'd0;
      out_secid_3    <= (cmd_q == CMD_RESOLVE) ? ids_q[3] : 32'd0;
      out_secid_4    <= (cmd_q == CMD_RESOLVE) ? ids_q[4] : 32'd0;
      out_secid_5    <= (cmd_q == CMD_RESOLVE) ? ids_q[5] : 32'd0;
      out_secid_6    <= (cmd_q == CMD_RESOLVE) ? ids_q[6] : 32'd0;
      out_secid_7    <= (cmd_q == CMD_RESOLVE) ? ids_q[7] : 32'd0;
    end
  end

  // entry tokens
  stlm_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_tok_ram (
    .clk   (clk),
    .we    (state == S_MAP_END),
    .waddr (victim),
    .wdata (new_token),
    .raddr (cnt[AW-1:0]),
    .rdata (tok_rdata)
  );

  // entry id sets, one full set per word
  stlm_ram #(.WIDTH(IDS_W), .DEPTH(ENTRIES)) u_ids_ram (
    .clk   (clk),
    .we    (state == S_MAP_END),
    .waddr (victim),
    .wdata (IDS_W'(ids_q)),
    .raddr (ids_raddr),
    .rdata (ids_rdata)
  );

  // entry ages
  stlm_ram #(.WIDTH(30), .DEPTH(ENTRIES)) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_fresh),
    .raddr (cnt[AW-1:0]),
    .rdata (age_rdata)
  );

`ifndef ASSERT_OFF
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(ENTRIES)) else $error("fill count above table size");

  a_rd_filled: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> (CW'(rd_addr) < fill)) else $error("scan read beyond filled entries");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE)) else $error("result without finish");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (fill != $past(fill)) |-> $past(state == S_MAP_END)) else $error("fill moved outside alloc");
`endif

endmodule

// ----- tb/sv/tb_secid_token_lru_map.sv -----
// Testbench for secid_token_lru_map: a table predictor checks every result.
`timescale 1ns / 1ps

// Expected contents of one result transfer.
typedef struct {
  logic [31:0]         tok;
  logic [31:0]         sel;
  stlm_pkg::ids_t      ids;
} lru_result_t;

// Holds a shadow copy of the token table and the results still owed by the block.
class lru_table_scoreboard;
  logic [31:0]          ent_tok [stlm_pkg::ENTRIES];
  stlm_pkg::ids_t       ent_ids [stlm_pkg::ENTRIES];
  logic [29:0]          ent_age [stlm_pkg::ENTRIES];
  int                   fill;
  logic [29:0]          tok_cnt;
  logic [29:0]          age_cnt;
  lru_result_t          pending[$];
  int                   errors;
  int                   evictions;
  int                   hits;
  int                   checked;

  function new();
    fill = 0;
    tok_cnt = '0;
    age_cnt = '0;
    errors = 0;
    evictions = 0;
    hits = 0;
    checked = 0;
    foreach (ent_tok[i]) ent_tok[i] = '0;
  endfunction

  function logic [29:0] next_age();
    if (age_cnt >= stlm_pkg::AGE_WRAP) age_cnt = '0;
    age_cnt = age_cnt + 1'b1;
    return age_cnt;
  endfunction

  function logic [31:0] alloc_token();
    if (tok_cnt >= stlm_pkg::TOKEN_WRAP) tok_cnt = '0;
    tok_cnt = tok_cnt + 1'b1;
    return {2'b10, tok_cnt};
  endfunction

  // Token to ids; a found entry gets a fresh age.
  function stlm_pkg::ids_t lookup_ids(logic [31:0] t);
    stlm_pkg::ids_t r;
    r = '0;
    if (t == '0) return r;
    if (!t[31]) begin
      for (int m = 0; m < stlm_pkg::MODULES; m++) r[m] = t;
      return r;
    end
    for (int i = 0; i < fill; i++) begin
      if (ent_tok[i] == t) begin
        ent_age[i] = next_age();
        return ent_ids[i];
      end
    end
    return r;
  endfunction

  // Ids to token; allocates on a miss, evicting the oldest entry when full.
  function logic [31:0] map_to_token(stlm_pkg::ids_t s);
    int v;
    if (s == '0) return '0;
    for (int i = 0; i < fill; i++) begin
      if (ent_ids[i] == s) begin
        ent_age[i] = next_age();
        hits++;
        return ent_tok[i];
      end
    end
    if (fill < stlm_pkg::ENTRIES) begin
      v = fill;
      fill++;
    end else begin
      v = 0;
      for (int j = 1; j < stlm_pkg::ENTRIES; j++)
        if (ent_age[j] < ent_age[v]) v = j;
      evictions++;
    end
    ent_ids[v] = s;
    ent_tok[v] = alloc_token();
    ent_age[v] = next_age();
    return ent_tok[v];
  endfunction

  // Called on each accepted input transfer.
  function void note_input(stlm_pkg::cmd_t c, logic [31:0] t, logic [2:0] idx,
                           logic [31:0] nid, stlm_pkg::ids_t s);
    lru_result_t e;
    stlm_pkg::ids_t w;
    e.tok = '0;
    e.sel = '0;
    e.ids = '0;
    case (c)
      stlm_pkg::CMD_MAP: e.tok = map_to_token(s);
      stlm_pkg::CMD_RESOLVE: e.ids = lookup_ids(t);
      stlm_pkg::CMD_GET: begin
        w = lookup_ids(t);
        e.sel = w[idx];
      end
      default: begin
        w = lookup_ids(t);
        if (t != '0 && w[idx] == nid) begin
          e.tok = t;
        end else begin
          w[idx] = nid;
          e.tok = map_to_token(w);
        end
      end
    endcase
    pending.push_back(e);
  endfunction

  // Called on each accepted output transfer.
  function void check_result(lru_result_t a);
    lru_result_t e;
    checked++;
    if (pending.size() == 0) begin
      $error("result transfer with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.tok !== e.tok) begin
      $error("token_out: expected %h, got %h", e.tok, a.tok);
      errors++;
    end
    if (a.sel !== e.sel) begin
      $error("selected_secid: expected %h, got %h", e.sel, a.sel);
      errors++;
    end
    for (int m = 0; m < stlm_pkg::MODULES; m++) begin
      if (a.ids[m] !== e.ids[m]) begin
        $error("out_secid_%0d: expected %h, got %h", m, e.ids[m], a.ids[m]);
        errors++;
      end
    end
  endfunction

  // A token currently in the table, or 0 when it is empty.
  function logic [31:0] any_token();
    if (fill == 0) return '0;
    return ent_tok[$urandom_range(fill - 1, 0)];
  endfunction

  function stlm_pkg::ids_t any_ids();
    if (fill == 0) return '0;
    return ent_ids[$urandom_range(fill - 1, 0)];
  endfunction
endclass

module tb_secid_token_lru_map;
  import stlm_pkg::*;

  localparam int RANDOM_ITEMS = 1125;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [31:0] token;
  logic [2:0]  module_index;
  logic [31:0] new_secid;
  logic [31:0] secid_0, secid_1, secid_2, secid_3;
  logic [31:0] secid_4, secid_5, secid_6, secid_7;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] token_out;
  logic [31:0] selected_secid;
  logic [31:0] out_secid_0, out_secid_1, out_secid_2, out_secid_3;
  logic [31:0] out_secid_4, out_secid_5, out_secid_6, out_secid_7;

  lru_table_scoreboard sb;
  longint cycles = 0;
  int     cmd_count [4];

  secid_token_lru_map dut (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stall before each transfer, then check on accept.
  initial begin
    int hold;
    lru_result_t a;
    out_stall = 1'b1;
    @(posedge clk);
    forever begin
      hold = $urandom_range(4, 0);
      if ($urandom_range(3, 0) == 0) hold = 0;
      out_stall <= (hold != 0);
      while (hold > 0) begin
        @(posedge clk);
        hold--;
        if (hold == 0) out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      a.tok = token_out;
      a.sel = selected_secid;
      a.ids = {out_secid_7, out_secid_6, out_secid_5, out_secid_4,
               out_secid_3, out_secid_2, out_secid_1, out_secid_0};
      sb.check_result(a);
    end
  end

  // Drive one input transfer and hand it to the scoreboard when accepted.
  task automatic send(cmd_t c, logic [31:0] t, logic [2:0] idx, logic [31:0] nid,
                      ids_t s, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(4, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    token        <= t;
    module_index <= idx;
    new_secid    <= nid;
    {secid_7, secid_6, secid_5, secid_4, secid_3, secid_2, secid_1, secid_0} <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(c, t, idx, nid, s);
    cmd_count[c]++;
  endtask

  function automatic ids_t rand_ids();
    ids_t s;
    int mode;
    mode = $urandom_range(9, 0);
    for (int m = 0; m < MODULES; m++) s[m] = $urandom();
    if (mode < 3) begin
      for (int m = 0; m < MODULES; m++)
        if ($urandom_range(1, 0)) s[m] = '0;
    end else if (mode < 6) begin
      if (sb.fill > 0) s = sb.any_ids();
    end else if (mode == 6) begin
      s = '0;
    end
    return s;
  endfunction

  function automatic logic [31:0] rand_token();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return {1'b0, 31'($urandom())};
      2: return {1'b1, 31'($urandom())};
      default: return sb.any_token();
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [31:0] t;
    sb = new();
    foreach (cmd_count[i]) cmd_count[i] = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_MAP;
    token = '0;
    module_index = '0;
    new_secid = '0;
    {secid_7, secid_6, secid_5, secid_4, secid_3, secid_2, secid_1, secid_0} = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, zero sets, hits, unknown tokens
    send(CMD_RESOLVE, 32'h8000_0001, 3'd0, '0, '0);
    send(CMD_MAP, '0, '0, '0, '0);
    send(CMD_MAP, '0, '0, '0, {MODULES{32'hFFFF_FFFF}});
    send(CMD_MAP, '0, '0, '0, {32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    send(CMD_MAP, '0, '0, '0, {MODULES{32'hFFFF_FFFF}}, 1'b1);
    t = sb.any_token();
    send(CMD_RESOLVE, t, 3'd7, '0, '0);
    send(CMD_RESOLVE, '0, 3'd0, '0, '0);
    send(CMD_RESOLVE, 32'h7FFF_FFFF, 3'd0, '0, '0);
    send(CMD_RESOLVE, 32'hFFFF_FFFF, 3'd0, '0, '0);
    send(CMD_GET, t, 3'd0, '0, '0);
    send(CMD_GET, t, 3'd7, '0, '0);
    send(CMD_GET, 32'h0000_1234, 3'd3, '0, '0);
    send(CMD_GET, 32'hFFFF_FFFF, 3'd3, '0, '0);
    send(CMD_SET, '0, 3'd2, 32'hDEAD_BEEF, '0);
    send(CMD_SET, '0, 3'd2, '0, '0);
    send(CMD_SET, 32'h8000_0002, 3'd0, 32'hFFFF_FFFF, '0);
    send(CMD_SET, 32'h8000_0002, 3'd0, 32'h0, '0);
    send(CMD_SET, 32'h0000_0055, 3'd5, 32'h0000_0055, '0);
    send(CMD_SET, 32'h0000_0055, 3'd5, 32'h0000_0066, '0);
    send(CMD_SET, 32'hFFFF_FFFF, 3'd1, 32'h1, '0);
    send(CMD_MAP, '0, '0, '0, {32'h8000_0000, {(MODULES-1){32'h0}}});

    // Random: enough fresh sets to fill the table and force evictions
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3: send(CMD_MAP, $urandom(), 3'($urandom()), $urandom(), rand_ids());
        4, 5: send(CMD_RESOLVE, rand_token(), 3'($urandom()), $urandom(), rand_ids());
        6, 7: send(CMD_GET, rand_token(), 3'($urandom()), $urandom(), rand_ids());
        default: begin
          t = rand_token();
          send(CMD_SET, t, 3'($urandom()),
               $urandom_range(3, 0) == 0 ? 32'h0 : $urandom(), rand_ids());
        end
      endcase
    end

    // Drain
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * ENTRIES + 20) @(posedge clk);

    $display("covered %0d map, %0d resolve, %0d get, %0d set transfers; %0d results",
             cmd_count[CMD_MAP], cmd_count[CMD_RESOLVE], cmd_count[CMD_GET],
             cmd_count[CMD_SET], sb.checked);
    $display("table filled %0d entries, %0d hits, %0d evictions",
             sb.fill, sb.hits, sb.evictions);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/stlm_pkg.sv
rtl/stlm_ram.sv
rtl/secid_token_lru_map.sv
tb/sv/tb_secid_token_lru_map.sv
